### hw/rtl/spbr_pkg.sv
// Shared widths, constants, types and the CORDIC angle table of the bin phase rotator.
package spbr_pkg;

  localparam int unsigned BINS_DEF  = 8192;
  localparam int unsigned IDX_W     = 13;
  localparam int unsigned IDX_CMP_W = 17;
  localparam int unsigned SW        = 24;
  localparam int unsigned PW        = 32;
  localparam int unsigned GUARD     = 8;
  localparam int unsigned STAGES    = 24;
  localparam int unsigned XW        = 36;
  localparam int unsigned ZW        = 32;

  // gain correction 1/K in Q30, rounding at bit 37, result taken from bit 38
  localparam int unsigned KW        = 30;
  localparam logic [KW-1:0] GAIN_Q30 = 30'd652032874;
  localparam int unsigned RND_SH    = 37;
  localparam int unsigned OUT_SH    = 38;
  localparam int unsigned LO_W      = 18;

  // output queue depth covers every word in flight
  localparam int unsigned Q_DEPTH   = 32;
  localparam int unsigned QAW       = $clog2(Q_DEPTH);
  localparam int unsigned QCW       = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_turns(input int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/spbr_front.sv
// Front end: index clamp, phase multiply, quadrant pre-rotation and guard scaling.
module spbr_front import spbr_pkg::*; #(
  parameter int unsigned BINS = BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [IDX_W-1:0]     in_bin_index,
  input  logic signed [SW-1:0] in_real,
  input  logic signed [SW-1:0] in_imag,
  input  logic [PW-1:0]        phase_step,
  output logic                 rot_valid,
  output rot_t                 rot
);

  localparam logic [IDX_CMP_W-1:0] BIN_LIM = IDX_CMP_W'(BINS);
  localparam logic [PW-1:0] QUARTER_HALF = PW'(1) << (PW - 3);
  localparam logic signed [ZW-1:0] Z_OFS = ZW'(QUARTER_HALF);
  localparam int unsigned EW = SW + 1;

  logic [IDX_CMP_W-1:0]    idx_wide;
  logic [IDX_CMP_W-1:0]    idx_clamp;
  logic [IDX_CMP_W+PW-1:0] prod;

  logic                    v1_r;
  logic [PW-1:0]           p_r;
  logic signed [SW-1:0]    re1_r;
  logic signed [SW-1:0]    im1_r;

  logic [PW-1:0]           p2;
  logic signed [EW-1:0]    re_w;
  logic signed [EW-1:0]    im_w;
  logic signed [EW-1:0]    xq;
  logic signed [EW-1:0]    yq;
  rot_t                    rot_nxt;
  logic                    v2_r;
  rot_t                    rot_r;

  always_comb begin
    idx_wide  = IDX_CMP_W'(in_bin_index);
    idx_clamp = (idx_wide >= BIN_LIM) ? (BIN_LIM - 1'b1) : idx_wide;
    prod      = idx_clamp * phase_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= prod[PW-1:0];
    re1_r <= in_real;
    im1_r <= in_imag;
  end

  always_comb begin
    p2   = p_r + QUARTER_HALF;
    re_w = EW'(re1_r);
    im_w = EW'(im1_r);
    case (quad_t'(p2[PW-1:PW-2]))
      QUAD_0: begin
        xq = re_w;
        yq = im_w;
      end
      QUAD_1: begin
        xq = -im_w;
        yq = re_w;
      end
      QUAD_2: begin
        xq = -re_w;
        yq = -im_w;
      end
      QUAD_3: begin
        xq = im_w;
        yq = -re_w;
      end
      default: begin
        xq = re_w;
        yq = im_w;
      end
    endcase
    rot_nxt.x = {{(XW - EW - GUARD){xq[EW-1]}}, xq, {GUARD{1'b0}}};
    rot_nxt.y = {{(XW - EW - GUARD){yq[EW-1]}}, yq, {GUARD{1'b0}}};
    rot_nxt.z = $signed({2'b00, p2[PW-3:0]}) - Z_OFS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign rot_valid = v2_r;
  assign rot       = rot_r;

endmodule

### hw/rtl/spbr_cell.sv
// One CORDIC micro-rotation cell: conditional shift-add on x, y and the residual angle.
module spbr_cell import spbr_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  rot_t in_rot,
  output logic out_valid,
  output rot_t out_rot
);

  localparam logic signed [ZW-1:0] ANG = atan_turns(STAGE);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  rot_t                 rot_nxt;
  rot_t                 rot_r;
  logic                 valid_r;

  always_comb begin
    dx = in_rot.y >>> STAGE;
    dy = in_rot.x >>> STAGE;
    if (!in_rot.z[ZW-1]) begin
      rot_nxt.x = in_rot.x - dx;
      rot_nxt.y = in_rot.y + dy;
      rot_nxt.z = in_rot.z - ANG;
    end else begin
      rot_nxt.x = in_rot.x + dx;
      rot_nxt.y = in_rot.y - dy;
      rot_nxt.z = in_rot.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign out_valid = valid_r;
  assign out_rot   = rot_r;

endmodule

### hw/rtl/spbr_gain.sv
// Gain correction: split multiply by 1/K, round, shift and saturate to Q1.23.
module spbr_gain import spbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rot_t                 in_rot,
  output logic                 out_valid,
  output logic signed [SW-1:0] out_re,
  output logic signed [SW-1:0] out_im
);

  localparam int unsigned HI_W   = XW - LO_W;
  localparam int unsigned PLO_W  = LO_W + KW;
  localparam int unsigned PHI_W  = HI_W + KW + 1;
  localparam int unsigned SUM_W  = XW + KW + 2;
  localparam int unsigned SH_W   = SUM_W - OUT_SH;
  localparam logic signed [PHI_W-1:0] K_S = PHI_W'(GAIN_Q30);
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << RND_SH;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((1 << (SW - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(1 << (SW - 1));

  logic [PLO_W-1:0]        xlo_nxt, ylo_nxt;
  logic signed [PHI_W-1:0] xhi_nxt, yhi_nxt;
  logic [PLO_W-1:0]        xlo_r, ylo_r;
  logic signed [PHI_W-1:0] xhi_r, yhi_r;
  logic                    va_r;
  logic signed [SW-1:0]    re_nxt, im_nxt;
  logic signed [SW-1:0]    re_r, im_r;
  logic                    vb_r;

  function automatic logic signed [SW-1:0] scale_sat(
    input logic signed [PHI_W-1:0] hi,
    input logic [PLO_W-1:0]        lo
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SH_W-1:0]  sh;
    logic signed [SW-1:0]    res;
    sum = $signed({hi[PHI_W-1], hi, {LO_W{1'b0}}})
        + $signed({{(SUM_W - PLO_W){1'b0}}, lo}) + RND;
    sh  = sum[SUM_W-1:OUT_SH];
    if (sh > SAT_MAX) begin
      res = SAT_MAX[SW-1:0];
    end else if (sh < SAT_MIN) begin
      res = SAT_MIN[SW-1:0];
    end else begin
      res = sh[SW-1:0];
    end
    return res;
  endfunction

  always_comb begin
    xlo_nxt = PLO_W'(in_rot.x[LO_W-1:0]) * PLO_W'(GAIN_Q30);
    ylo_nxt = PLO_W'(in_rot.y[LO_W-1:0]) * PLO_W'(GAIN_Q30);
    xhi_nxt = PHI_W'($signed(in_rot.x[XW-1:LO_W])) * K_S;
    yhi_nxt = PHI_W'($signed(in_rot.y[XW-1:LO_W])) * K_S;
  end

  always_ff @(posedge clk) begin
    xlo_r <= xlo_nxt;
    ylo_r <= ylo_nxt;
    xhi_r <= xhi_nxt;
    yhi_r <= yhi_nxt;
  end

  always_comb begin
    re_nxt = scale_sat(xhi_r, xlo_r);
    im_nxt = scale_sat(yhi_r, ylo_r);
  end

  always_ff @(posedge clk) begin
    re_r <= re_nxt;
    im_r <= im_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  assign out_valid = vb_r;
  assign out_re    = re_r;
  assign out_im    = im_r;

endmodule

### hw/rtl/spbr_fifo.sv
// Output queue that absorbs words still in the pipeline while the consumer stalls.
module spbr_fifo import spbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic signed [SW-1:0] push_re,
  input  logic signed [SW-1:0] push_im,
  input  logic                 pop,
  output logic                 out_valid,
  output logic signed [SW-1:0] out_re,
  output logic signed [SW-1:0] out_im
);

  logic signed [SW-1:0] re_q [Q_DEPTH];
  logic signed [SW-1:0] im_q [Q_DEPTH];
  logic [QAW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]       cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      re_q[wr_ptr_r] <= push_re;
      im_q[wr_ptr_r] <= push_im;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_re    = re_q[rd_ptr_r];
  assign out_im    = im_q[rd_ptr_r];

endmodule

### hw/rtl/spectrum_bin_phase_rotator.sv
// Top level of the spectrum bin phase rotator: config register, cell chain and output queue.
//
// Rotates one complex Q1.23 spectrum bin per word by exp(j*2*pi*phi), with
// phi = bin_index * phase_step modulo one turn (2^32 = one turn), which applies a
// time shift in the frequency domain. A bin_index at or above BINS is clamped to
// BINS-1. The datapath is fully pipelined: one input word is taken every clock
// cycle while in_ready is high; each word passes in order through the index clamp
// and phase multiply register, the quadrant pre-rotation register, 24 CORDIC cells,
// the split gain multiply register, the saturation register and the output queue.
// The 32-entry output queue and an occupancy count keep the pipeline moving while
// out_ready is low; in_ready drops only when 32 words are in flight or waiting.
// phase_step is written through cfg_wr_en/cfg_wr_data and should only be changed
// while the block is empty.
module spectrum_bin_phase_rotator import spbr_pkg::*; #(
  parameter int unsigned BINS = BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     in_bin_index,
  input  logic signed [SW-1:0] in_real,
  input  logic signed [SW-1:0] in_imag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [SW-1:0] out_real,
  output logic signed [SW-1:0] out_imag,
  input  logic                 cfg_wr_en,
  input  logic [PW-1:0]        cfg_wr_data
);

  logic [PW-1:0]  phase_step_r;
  logic [QCW-1:0] occ_r, occ_nxt;
  logic           in_fire;
  logic           out_fire;

  logic           cell_v [STAGES+1];
  rot_t           cell_d [STAGES+1];

  logic                 gain_v;
  logic signed [SW-1:0] gain_re;
  logic signed [SW-1:0] gain_im;

  // phase step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
    end else if (cfg_wr_en) begin
      phase_step_r <= cfg_wr_data;
    end
  end

  // Count words accepted but not yet delivered; the queue can always hold them.
  assign in_ready = (occ_r < QCW'(Q_DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r + QCW'(in_fire) - QCW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  spbr_front #(
    .BINS (BINS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_bin_index (in_bin_index),
    .in_real      (in_real),
    .in_imag      (in_imag),
    .phase_step   (phase_step_r),
    .rot_valid    (cell_v[0]),
    .rot          (cell_d[0])
  );

  // CORDIC chain: each cell does one micro-rotation and hands off to the next
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    spbr_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cell_v[i]),
      .in_rot    (cell_d[i]),
      .out_valid (cell_v[i+1]),
      .out_rot   (cell_d[i+1])
    );
  end

  spbr_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cell_v[STAGES]),
    .in_rot    (cell_d[STAGES]),
    .out_valid (gain_v),
    .out_re    (gain_re),
    .out_im    (gain_im)
  );

  spbr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (gain_v),
    .push_re   (gain_re),
    .push_im   (gain_im),
    .pop       (out_fire),
    .out_valid (out_valid),
    .out_re    (out_real),
    .out_im    (out_imag)
  );

endmodule

### hw/rtl/spbr_checker.sv
// Port-level checker for the bin phase rotator, bound to the top level.
module spbr_checker import spbr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [SW-1:0] out_real,
  input logic signed [SW-1:0] out_imag
);

  logic [QCW:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + (QCW+1)'(in_valid && in_ready) - (QCW+1)'(out_valid && out_ready);
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag))
    else $error("result word changed while stalled");

  // no result word without an accepted input word behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result word with no pending input word");

  // back pressure once the queue capacity is spoken for
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == (QCW+1)'(Q_DEPTH) |-> !in_ready)
    else $error("input word accepted beyond queue capacity");

  // reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind spectrum_bin_phase_rotator spbr_checker u_spbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_real  (out_real),
  .out_imag  (out_imag)
);
